@@ sv/bms_pkg.sv @@
package bms_pkg;

	localparam int MAX_ROWS = 512;
	localparam int MAX_COLS = 512;

	localparam int ROW_AW = $clog2(MAX_ROWS);
	localparam int COL_AW = $clog2(MAX_COLS);
	localparam int BANK_AW = (ROW_AW - 1) + (COL_AW - 1);
	localparam int BANK_DEPTH = 2 ** BANK_AW;
	localparam int NUM_BANKS = 4;

	// signed tap coordinate: holds floor(coord/256)+1 and the frame limit
	localparam int TAP_W = 14;

	localparam int CFG_W = 10;
	localparam logic [CFG_W-1:0] FRAME_RESET = CFG_W'(512);

	localparam logic REG_FRAME_HEIGHT = 1'b0;
	localparam logic REG_FRAME_WIDTH = 1'b1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// tap order: 0 = (y0,x0), 1 = (y0,x0+1), 2 = (y0+1,x0), 3 = (y0+1,x0+1)
	// bank index: {row parity, column parity}
	typedef struct packed {
		logic                               is_sample;
		logic [NUM_BANKS-1:0]               wr_en;
		logic [NUM_BANKS-1:0][BANK_AW-1:0]  addr;
		logic signed [15:0]                 wr_data;
		logic                               sel_row;
		logic                               sel_col;
		logic [NUM_BANKS-1:0]               tap_ok;
		logic [7:0]                         fx;
		logic [7:0]                         fy;
		logic                               last;
	} item_t;

endpackage

@@ sv/bms_front.sv @@
module bms_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          req_type,
	input  logic [8:0]                    pix_row,
	input  logic [8:0]                    pix_col,
	input  logic signed [15:0]            pix_value,
	input  logic signed [19:0]            x_coord,
	input  logic signed [19:0]            y_coord,
	input  logic                          last_point,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [bms_pkg::CFG_W-1:0]     cfg_data,
	input  logic [bms_pkg::QCNT_W-1:0]    level,
	output logic                          busy,
	output logic                          push,
	output bms_pkg::item_t                push_item
);

	logic [bms_pkg::CFG_W-1:0] frame_height_q;
	logic [bms_pkg::CFG_W-1:0] frame_width_q;
	logic                      valid_s1;
	bms_pkg::item_t            item_s1;
	bms_pkg::item_t            item;
	logic                      accept;

	logic signed [bms_pkg::TAP_W-1:0] row0, row1, col0, col1;
	logic signed [bms_pkg::TAP_W-1:0] h_lim, w_lim;
	logic                             row0_ok, row1_ok, col0_ok, col1_ok;
	logic [bms_pkg::TAP_W-1:0]        even_row, odd_row, even_col, odd_col;
	logic [bms_pkg::ROW_AW-1:0]       wr_row;
	logic [bms_pkg::COL_AW-1:0]       wr_col;

	assign busy = level > bms_pkg::QCNT_W'(bms_pkg::QUEUE_DEPTH - 2);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_height_q <= bms_pkg::FRAME_RESET;
			frame_width_q <= bms_pkg::FRAME_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bms_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				bms_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign row0 = {{(bms_pkg::TAP_W - 12){y_coord[19]}}, y_coord[19:8]};
	assign col0 = {{(bms_pkg::TAP_W - 12){x_coord[19]}}, x_coord[19:8]};
	assign row1 = row0 + bms_pkg::TAP_W'(1);
	assign col1 = col0 + bms_pkg::TAP_W'(1);

	assign h_lim = (int'(frame_height_q) > bms_pkg::MAX_ROWS) ?
		bms_pkg::TAP_W'(bms_pkg::MAX_ROWS) : bms_pkg::TAP_W'(frame_height_q);
	assign w_lim = (int'(frame_width_q) > bms_pkg::MAX_COLS) ?
		bms_pkg::TAP_W'(bms_pkg::MAX_COLS) : bms_pkg::TAP_W'(frame_width_q);

	assign row0_ok = !row0[bms_pkg::TAP_W-1] && (row0 < h_lim);
	assign row1_ok = !row1[bms_pkg::TAP_W-1] && (row1 < h_lim);
	assign col0_ok = !col0[bms_pkg::TAP_W-1] && (col0 < w_lim);
	assign col1_ok = !col1[bms_pkg::TAP_W-1] && (col1 < w_lim);

	assign even_row = row0[0] ? row1 : row0;
	assign odd_row = row0[0] ? row0 : row1;
	assign even_col = col0[0] ? col1 : col0;
	assign odd_col = col0[0] ? col0 : col1;

	assign wr_row = bms_pkg::ROW_AW'(pix_row);
	assign wr_col = bms_pkg::COL_AW'(pix_col);

	always_comb begin
		logic [bms_pkg::TAP_W-1:0] r_sel;
		logic [bms_pkg::TAP_W-1:0] c_sel;
		item = '0;
		r_sel = '0;
		c_sel = '0;
		item.wr_data = pix_value;
		item.fx = x_coord[7:0];
		item.fy = y_coord[7:0];
		item.last = last_point;
		item.sel_row = row0[0];
		item.sel_col = col0[0];
		item.tap_ok = {row1_ok && col1_ok, row1_ok && col0_ok,
			row0_ok && col1_ok, row0_ok && col0_ok};
		if (req_type == bms_pkg::REQ_SAMPLE) begin
			item.is_sample = 1'b1;
			for (int b = 0; b < bms_pkg::NUM_BANKS; b++) begin
				r_sel = b[1] ? odd_row : even_row;
				c_sel = b[0] ? odd_col : even_col;
				item.addr[b] = {r_sel[bms_pkg::ROW_AW-1:1], c_sel[bms_pkg::COL_AW-1:1]};
			end
		end else begin
			item.is_sample = 1'b0;
			for (int b = 0; b < bms_pkg::NUM_BANKS; b++) begin
				item.addr[b] = {wr_row[bms_pkg::ROW_AW-1:1], wr_col[bms_pkg::COL_AW-1:1]};
			end
			if (int'(pix_row) < bms_pkg::MAX_ROWS && int'(pix_col) < bms_pkg::MAX_COLS) begin
				item.wr_en = bms_pkg::NUM_BANKS'(1) << {wr_row[0], wr_col[0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	assign push = valid_s1;
	assign push_item = item_s1;

endmodule

@@ sv/bms_queue.sv @@
module bms_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  bms_pkg::item_t                push_item,
	output logic                          pop,
	output bms_pkg::item_t                pop_item,
	output logic [bms_pkg::QCNT_W-1:0]    level
);

	bms_pkg::item_t                entry_q [bms_pkg::QUEUE_DEPTH];
	logic [bms_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [bms_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [bms_pkg::QCNT_W-1:0]    count_q;

	function automatic logic [bms_pkg::QPTR_W-1:0] next_ptr(
		input logic [bms_pkg::QPTR_W-1:0] p
	);
		return (p == bms_pkg::QPTR_W'(bms_pkg::QUEUE_DEPTH - 1)) ?
			'0 : p + bms_pkg::QPTR_W'(1);
	endfunction

	// the back end never stalls: drain one entry per cycle
	assign pop = count_q != '0;
	assign pop_item = entry_q[rd_ptr_q];
	assign level = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + bms_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bms_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ sv/bms_back.sv @@
module bms_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop,
	input  bms_pkg::item_t       pop_item,
	output logic                 sample_valid,
	output logic signed [15:0]   sample_value,
	output logic                 last_sample
);

	logic signed [15:0]         rd_s1 [bms_pkg::NUM_BANKS];
	logic                       valid_s1, valid_s2, valid_s3;
	logic                       sel_row_s1, sel_col_s1;
	logic [bms_pkg::NUM_BANKS-1:0] tap_ok_s1;
	logic [7:0]                 fx_s1, fy_s1, fy_s2;
	logic                       last_s1, last_s2, last_s3;

	logic signed [15:0]         p00, p01, p10, p11;
	logic signed [16:0]         d0, d1;
	logic signed [25:0]         r0, r1;
	logic signed [25:0]         r0_s2, r1_s2;
	logic signed [26:0]         dr;
	logic signed [35:0]         v;
	logic signed [35:0]         v_s3;
	logic signed [36:0]         rounded;
	logic signed [20:0]         q;

	logic                       sample_valid_q;
	logic signed [15:0]         sample_value_q;
	logic                       last_sample_q;

	for (genvar b = 0; b < bms_pkg::NUM_BANKS; b++) begin : g_bank
		logic signed [15:0] bank_mem_q [bms_pkg::BANK_DEPTH];
		always_ff @(posedge clk) begin
			if (pop && pop_item.wr_en[b]) begin
				bank_mem_q[pop_item.addr[b]] <= pop_item.wr_data;
			end
			rd_s1[b] <= bank_mem_q[pop_item.addr[b]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			sample_valid_q <= 1'b0;
		end else begin
			valid_s1 <= pop && pop_item.is_sample;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			sample_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sel_row_s1 <= pop_item.sel_row;
		sel_col_s1 <= pop_item.sel_col;
		tap_ok_s1 <= pop_item.tap_ok;
		fx_s1 <= pop_item.fx;
		fy_s1 <= pop_item.fy;
		last_s1 <= pop_item.last;
	end

	// x lerp on both rows
	assign p00 = tap_ok_s1[0] ? rd_s1[{sel_row_s1, sel_col_s1}] : 16'sd0;
	assign p01 = tap_ok_s1[1] ? rd_s1[{sel_row_s1, ~sel_col_s1}] : 16'sd0;
	assign p10 = tap_ok_s1[2] ? rd_s1[{~sel_row_s1, sel_col_s1}] : 16'sd0;
	assign p11 = tap_ok_s1[3] ? rd_s1[{~sel_row_s1, ~sel_col_s1}] : 16'sd0;

	assign d0 = {p01[15], p01} - {p00[15], p00};
	assign d1 = {p11[15], p11} - {p10[15], p10};
	assign r0 = $signed({{2{p00[15]}}, p00, 8'h00}) + $signed({1'b0, fx_s1}) * d0;
	assign r1 = $signed({{2{p10[15]}}, p10, 8'h00}) + $signed({1'b0, fx_s1}) * d1;

	always_ff @(posedge clk) begin
		r0_s2 <= r0;
		r1_s2 <= r1;
		fy_s2 <= fy_s1;
		last_s2 <= last_s1;
	end

	// y lerp
	assign dr = {r1_s2[25], r1_s2} - {r0_s2[25], r0_s2};
	assign v = $signed({{2{r0_s2[25]}}, r0_s2, 8'h00}) + $signed({1'b0, fy_s2}) * dr;

	always_ff @(posedge clk) begin
		v_s3 <= v;
		last_s3 <= last_s2;
	end

	// round half up, then saturate
	assign rounded = {v_s3[35], v_s3} + 37'sd32768;
	assign q = rounded[36:16];

	always_ff @(posedge clk) begin
		if (q > 21'sd32767) begin
			sample_value_q <= 16'sh7fff;
		end else if (q < -21'sd32768) begin
			sample_value_q <= 16'sh8000;
		end else begin
			sample_value_q <= q[15:0];
		end
		last_sample_q <= last_s3;
	end

	assign sample_valid = sample_valid_q;
	assign sample_value = sample_value_q;
	assign last_sample = last_sample_q;

endmodule

@@ sv/bilinear_map_sampler.sv @@
// channel   | handshake                      | payload
// ----------+--------------------------------+-----------------------------------------
// request   | start, accepted when !busy     | req_type pix_row pix_col pix_value
//           |                                | x_coord y_coord last_point
// config    | cfg_valid / cfg_ready          | cfg_index cfg_data
// result    | sample_valid, one-cycle strobe | sample_value last_sample
//
// One request per cycle sustained: each request makes a single access to the four-bank map
// (banks split by row and column parity, so all four taps come from one read).
// A sample passes front reg, queue, map read, x/y lerp, output reg; writes give none.
// Reset clears control and sets both frame registers to 512; map contents stay undefined.
// The result side cannot stall; busy rises only when the request queue fills.
module bilinear_map_sampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [8:0]                    pix_row,
	input  logic [8:0]                    pix_col,
	input  logic signed [15:0]            pix_value,
	input  logic signed [19:0]            x_coord,
	input  logic signed [19:0]            y_coord,
	input  logic                          last_point,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [bms_pkg::CFG_W-1:0]     cfg_data,
	output logic                          sample_valid,
	output logic signed [15:0]            sample_value,
	output logic                          last_sample
);

	logic                          push;
	bms_pkg::item_t                push_item;
	logic                          pop;
	bms_pkg::item_t                pop_item;
	logic [bms_pkg::QCNT_W-1:0]    level;

	assign cfg_ready = 1'b1;

	bms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.pix_row    (pix_row),
		.pix_col    (pix_col),
		.pix_value  (pix_value),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.last_point (last_point),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.level      (level),
		.busy       (busy),
		.push       (push),
		.push_item  (push_item)
	);

	bms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.level     (level)
	);

	bms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (pop),
		.pop_item     (pop_item),
		.sample_valid (sample_valid),
		.sample_value (sample_value),
		.last_sample  (last_sample)
	);

endmodule
